FILE: rtl/gdc_pkg.sv
// Package with the shared types, constants and codes of the drift correction block.
`default_nettype none
package gdc_pkg;
	localparam int MaxPoints = 1024;
	localparam int MaxWindow = 64;
	localparam int PtAw = $clog2(MaxPoints);
	localparam int CntW = PtAw + 1;
	localparam int WtAw = $clog2(MaxWindow + 1);

	typedef enum logic [1:0] {
		REQ_POINT  = 2'd0,
		REQ_WEIGHT = 2'd1,
		REQ_CORR   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_RISE = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam logic [0:0] REG_WINDOW = 1'b0;
	localparam logic [0:0] REG_SMOOTH = 1'b1;

	// Request from the controller to the divider.
	typedef struct packed {
		logic              start;
		logic signed [63:0] num;
		logic [31:0]        den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/gdc_div.sv
// Bit-serial rounding divider: signed 64-bit numerator by unsigned 32-bit denominator.
`default_nettype none
module gdc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gdc_pkg::div_req_t req,
	output gdc_pkg::div_rsp_t      rsp
);
	import gdc_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] mag;
	logic [64:0] trial;
	logic [63:0] rnd;

	// Magnitude plus half the denominator gives round half away from zero.
	assign mag = req.num[63] ? (64'd0 - 64'(req.num)) : 64'(req.num);
	assign rnd = mag + {33'd0, req.den[31:1]};
	assign trial = {rem_q, quo_q[63]} - {33'd0, den_q};

	// One quotient bit a cycle, restoring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= rnd;
			den_q <= req.den;
			neg_q <= req.num[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	// The magnitude of a weighted mean of 32-bit values is at most 2^31, so the low
	// 32 bits negate correctly to the most negative value.
	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? (32'sd0 - $signed(quo_q[31:0])) : $signed(quo_q[31:0]);
endmodule
`default_nettype wire

FILE: rtl/gdc_mem.sv
// Point and weight memories, each with a single registered read port.
`default_nettype none
module gdc_mem (
	input  wire logic                      clk,
	input  wire logic                      pt_we,
	input  wire logic [gdc_pkg::PtAw-1:0]  pt_addr,
	input  wire logic [23:0]               pt_wtime,
	input  wire logic [95:0]               pt_wcorr,
	output logic [23:0]                    pt_rtime,
	output logic [95:0]                    pt_rcorr,
	input  wire logic                      wt_we,
	input  wire logic [gdc_pkg::WtAw-1:0]  wt_addr,
	input  wire logic [15:0]               wt_wdata,
	output logic [15:0]                    wt_rdata
);
	import gdc_pkg::*;

	logic [119:0] pt_mem [MaxPoints];
	logic [15:0]  wt_mem [MaxWindow+1];

	// Point store: time and correction side by side.
	always_ff @(posedge clk) begin
		if (pt_we) pt_mem[pt_addr] <= {pt_wtime, pt_wcorr};
		{pt_rtime, pt_rcorr} <= pt_mem[pt_addr];
	end

	// Weight store.
	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[wt_addr] <= wt_wdata;
		wt_rdata <= wt_mem[wt_addr];
	end
endmodule
`default_nettype wire

FILE: rtl/gaussian_drift_correction.sv
// Top level of the Gaussian drift correction block: control, datapath and APB registers.
// Sequence: a load passes through S_LOAD and S_OUT; a correction runs three binary searches of up
// to 11 steps each, then, with smoothing on, a weighted walk over the window's points (up to 129)
// and three divisions, or else a pick of the nearest point.
// One transaction at a time: a new request is taken only in S_IDLE.
// Reset clears the point count and control state and sets window 20, smoothing on.
`default_nettype none
module gaussian_drift_correction (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [23:0] frame,
	input  wire logic signed [31:0] x_in,
	input  wire logic signed [31:0] y_in,
	input  wire logic signed [31:0] z_in,
	input  wire logic [6:0]  weight_index,
	input  wire logic [15:0] weight_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic signed [31:0] z_out,
	output logic [1:0]       status
);
	import gdc_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_LOAD  = 11'b00000000010,
		S_SRCH  = 11'b00000000100,
		S_SRCHW = 11'b00000001000,
		S_WALK  = 11'b00000010000,
		S_WALKW = 11'b00000100000,
		S_WACC  = 11'b00001000000,
		S_DIV   = 11'b00010000000,
		S_NEAR  = 11'b00100000000,
		S_NEARW = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [6:0]  window_q;
	logic        smooth_q;
	logic [CntW-1:0] count_q;
	logic [23:0] last_time_q;

	// Held transaction.
	logic [1:0]  req_q;
	logic [23:0] frame_q;
	logic signed [31:0] pos_q [3];
	logic [6:0]  widx_q;
	logic [15:0] wval_q;

	// Search state.
	logic [1:0]       phase_q;   // 0 begin, 1 end, 2 closest
	logic [CntW-1:0]  lo_q, hi_q;
	logic [CntW-1:0]  begin_q, end_q, close_q;
	logic [25:0]      key_q;
	logic [CntW-1:0]  walk_q;
	logic signed [63:0] acc_q [3];
	logic [31:0]      wsum_q;
	logic [1:0]       axis_q;
	logic             div_first_q;
	logic signed [31:0] corr_q [3];
	logic [23:0]      ntime_q;
	logic             near_second_q;
	logic [CntW-1:0]  pick_q;

	logic        out_valid_q;
	logic signed [31:0] xo_q, yo_q, zo_q;
	logic [1:0]  status_q;

	// Memory ports.
	logic              pt_we;
	logic [PtAw-1:0]   pt_addr;
	logic [23:0]       pt_rtime;
	logic [95:0]       pt_rcorr;
	logic              wt_we;
	logic [WtAw-1:0]   wt_addr;
	logic [15:0]       wt_rdata;

	div_req_t dreq;
	div_rsp_t drsp;

	logic [CntW-1:0] mid;
	logic [CntW-1:0] walk_nx;
	logic [6:0]      range;
	logic [25:0]     tdiff;
	logic [24:0]     abs_diff;
	logic signed [31:0] pcorr [3];

	gdc_mem u_mem (
		.clk(clk), .pt_we(pt_we), .pt_addr(pt_addr), .pt_wtime(frame_q),
		.pt_wcorr({pos_q[2], pos_q[1], pos_q[0]}), .pt_rtime(pt_rtime), .pt_rcorr(pt_rcorr),
		.wt_we(wt_we), .wt_addr(wt_addr), .wt_wdata(wval_q), .wt_rdata(wt_rdata)
	);

	gdc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign walk_nx = walk_q + 1'b1;
	assign range = (window_q > 7'(MaxWindow)) ? 7'(MaxWindow) : window_q;
	assign pcorr[0] = $signed(pt_rcorr[31:0]);
	assign pcorr[1] = $signed(pt_rcorr[63:32]);
	assign pcorr[2] = $signed(pt_rcorr[95:64]);
	assign tdiff = {2'b00, pt_rtime} - {2'b00, frame_q};
	assign abs_diff = tdiff[25] ? 25'(26'd0 - tdiff) : tdiff[24:0];

	// Memory address and write enables by state.
	// While walking, the point time arrives in S_WALKW and addresses the weight store;
	// S_WACC then uses the weight and the still held correction, and fetches the next point.
	always_comb begin
		pt_we   = 1'b0;
		wt_we   = 1'b0;
		pt_addr = mid[PtAw-1:0];
		wt_addr = pt_addr[WtAw-1:0];
		unique case (state_q)
			S_LOAD: begin
				pt_addr = count_q[PtAw-1:0];
				pt_we   = (req_q == REQ_POINT) && (count_q < CntW'(MaxPoints))
				          && ((count_q == '0) || (last_time_q < frame_q));
				wt_addr = widx_q[WtAw-1:0];
				wt_we   = (req_q == REQ_WEIGHT) && (widx_q <= 7'(MaxWindow));
			end
			S_WALK: pt_addr = walk_q[PtAw-1:0];
			S_WALKW: begin
				pt_addr = walk_q[PtAw-1:0];
				wt_addr = (abs_diff > 25'(MaxWindow)) ? WtAw'(MaxWindow)
				                                      : abs_diff[WtAw-1:0];
			end
			S_WACC: pt_addr = walk_nx[PtAw-1:0];
			S_NEAR, S_NEARW: pt_addr = pick_q[PtAw-1:0];
			default: pt_addr = mid[PtAw-1:0];
		endcase
	end

	// Divider request for the current axis.
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = acc_q[0];
		dreq.den   = wsum_q;
		if (state_q == S_DIV) begin
			dreq.start = div_first_q || (drsp.done && (axis_q != 2'd2));
			if (!div_first_q) dreq.num = (axis_q == 2'd0) ? acc_q[1] : acc_q[2];
		end
	end

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] p,
	                                                input logic signed [31:0] c);
		logic signed [32:0] d;
		d = 33'(p) - 33'(c);
		if (d > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (d < -33'sh0_8000_0000) return 32'sh8000_0000;
		return d[31:0];
	endfunction

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			div_first_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					if (req_type == REQ_CORR) state_q <= S_SRCH;
					else state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (pt_we) count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_SRCH: begin
					if (count_q == '0) state_q <= S_OUT;
					else if (lo_q < hi_q) state_q <= S_SRCHW;
					else if (phase_q == 2'd2) state_q <= S_WALK;
					else state_q <= S_SRCH;
				end
				S_SRCHW: state_q <= S_SRCH;
				S_WALK: begin
					if (smooth_q && walk_q < end_q) state_q <= S_WALKW;
					else state_q <= S_NEAR;
				end
				S_WALKW: state_q <= S_WACC;
				S_WACC: begin
					if (walk_nx < end_q) state_q <= S_WALKW;
					else if (wsum_q + 32'(wt_rdata) != 0) begin
						state_q     <= S_DIV;
						div_first_q <= 1'b1;
					end else state_q <= S_NEAR;
				end
				S_DIV: begin
					div_first_q <= 1'b0;
					if (drsp.done && axis_q == 2'd2) state_q <= S_OUT;
				end
				S_NEAR: state_q <= S_NEARW;
				S_NEARW: begin
					if (near_second_q) state_q <= S_OUT;
					else state_q <= S_NEAR;
				end
				S_OUT: if (!out_valid_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Data registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q    <= req_type;
				frame_q  <= frame;
				pos_q[0] <= x_in;
				pos_q[1] <= y_in;
				pos_q[2] <= z_in;
				widx_q   <= weight_index;
				wval_q   <= weight_value;
				phase_q  <= 2'd0;
				lo_q     <= '0;
				hi_q     <= count_q;
				key_q    <= {2'b00, frame} - 26'(range);
				status_q <= ST_OK;
				near_second_q <= 1'b0;
				for (int a = 0; a < 3; a++) begin
					acc_q[a]  <= '0;
					corr_q[a] <= '0;
				end
				wsum_q <= '0;
				axis_q <= 2'd0;
			end
			S_LOAD: begin
				if (req_q == REQ_POINT) begin
					if (count_q >= CntW'(MaxPoints)) status_q <= ST_FULL;
					else if (!pt_we) status_q <= ST_NOT_RISE;
					else last_time_q <= frame_q;
				end
			end
			S_SRCH: begin
				if (count_q == '0) begin
					status_q <= ST_EMPTY;
				end else if (lo_q >= hi_q) begin
					lo_q <= '0;
					hi_q <= count_q;
					phase_q <= phase_q + 2'd1;
					unique case (phase_q)
						2'd0: begin
							begin_q <= lo_q;
							key_q   <= {2'b00, frame_q} + 26'(range) + 26'd1;
						end
						2'd1: begin
							end_q <= lo_q;
							key_q <= {2'b00, frame_q};
						end
						default: begin
							close_q <= lo_q;
							walk_q  <= begin_q;
						end
					endcase
				end
			end
			S_SRCHW: begin
				if ($signed({2'b00, pt_rtime}) < $signed(key_q)) lo_q <= mid + 1'b1;
				else hi_q <= mid;
			end
			S_WALK: begin
				if (close_q >= count_q) pick_q <= count_q - 1'b1;
				else if (close_q == '0) pick_q <= '0;
				else pick_q <= close_q;
			end
			S_WACC: begin
				for (int a = 0; a < 3; a++)
					acc_q[a] <= acc_q[a] + pcorr[a] * $signed({1'b0, wt_rdata});
				wsum_q <= wsum_q + 32'(wt_rdata);
				walk_q <= walk_nx;
			end
			S_DIV: if (drsp.done) begin
				corr_q[axis_q] <= drsp.quo;
				axis_q <= axis_q + 2'd1;
			end
			S_NEARW: begin
				// First read is the point at or after the frame (the last point if there is none); second the one before.
				if (!near_second_q) begin
					corr_q[0] <= pcorr[0];
					corr_q[1] <= pcorr[1];
					corr_q[2] <= pcorr[2];
					ntime_q   <= pt_rtime;
					if (close_q < count_q && close_q != '0) begin
						near_second_q <= 1'b1;
						pick_q <= close_q - 1'b1;
					end else begin
						near_second_q <= 1'b1;
						pick_q <= pick_q;
					end
				end else if (close_q < count_q && close_q != '0 &&
				             !((ntime_q - frame_q) < (frame_q - pt_rtime))) begin
					corr_q[0] <= pcorr[0];
					corr_q[1] <= pcorr[1];
					corr_q[2] <= pcorr[2];
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			status <= status_q;
			if (req_q == REQ_CORR) begin
				xo_q <= sat_sub(pos_q[0], corr_q[0]);
				yo_q <= sat_sub(pos_q[1], corr_q[1]);
				zo_q <= sat_sub(pos_q[2], corr_q[2]);
			end else begin
				xo_q <= '0;
				yo_q <= '0;
				zo_q <= '0;
			end
		end
	end

	assign x_out     = xo_q;
	assign y_out     = yo_q;
	assign z_out     = zo_q;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 7'd20;
			smooth_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WINDOW && paddr[1:0] == 2'b00) window_q <= pwdata[6:0];
			if (paddr[2] == REG_SMOOTH && paddr[1:0] == 2'b00) smooth_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SMOOTH) ? {31'd0, smooth_q} : {25'd0, window_q};

	property p_cnt_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CntW'(MaxPoints);
	endproperty
	a_cnt_bound: assert property (p_cnt_bound) else $error("point count above capacity");

	property p_ready_out;
		@(posedge clk) disable iff (!arst_n) (state_q == S_OUT) |-> !in_ready;
	endproperty
	a_ready_out: assert property (p_ready_out) else $error("ready while result pending");

	property p_empty_status;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_SRCH && count_q == '0) |=> (status_q == ST_EMPTY);
	endproperty
	a_empty_status: assert property (p_empty_status) else $error("empty table not flagged");
endmodule
`default_nettype wire
